// File: hdl/ugnq_pkg.sv
package ugnq_pkg;

  localparam int MaxAgents   = 64;
  localparam int MaxGridSide = 16;
  localparam int IdW         = 6;
  localparam int CellW       = 8;
  localparam int CountW      = 7;
  localparam int PosW        = 24;
  localparam int SizeW       = 23;
  localparam int SideW       = 5;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 24;
  localparam int SlotW       = 4;
  localparam int WideW       = 30;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_MOVE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS   = 3'd0,
    CFG_COLS   = 3'd1,
    CFG_CW     = 3'd2,
    CFG_CH     = 3'd3,
    CFG_ORG_X  = 3'd4,
    CFG_ORG_Y  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [IdW-1:0]         agent_id;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] old_x;
    logic signed [PosW-1:0] old_y;
    logic [SizeW-1:0]       radius;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [IdW-1:0]    neighbor_id;
    logic [CellW-1:0]  cell_index;
    logic [CountW-1:0] neighbor_count;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

// File: hdl/ugnq_if.sv
interface ugnq_req_if import ugnq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ugnq_rsp_if import ugnq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ugnq_cfg_if import ugnq_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/uniform_grid_neighbor_query_unit.sv
// Uniform grid neighbor store for up to 64 agents on a grid of up to 16 x 16 cells. Requests
// are handled one at a time and the request channel is not ready while one is in progress.
// Each cell slot (row or column) is found by stepping one shared adder/comparator through
// successive cell boundaries, one boundary a cycle; an add maps its new position and a
// move maps both its new and its old position. A query first walks the rows and then the
// columns of the current grid to find the rectangle of overlapping cells, then scans all
// 64 agent slots for every cell of that rectangle, waiting on each slot for the cell table,
// which is read through a register, and emits one response per neighbor, ordered by cell
// then by id. Responses are held in an output register, so the next request may be
// accepted while the last response waits.
module uniform_grid_neighbor_query_unit
  import ugnq_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  ugnq_cfg_if.sink     cfg,
  ugnq_req_if.sink     req,
  ugnq_rsp_if.source   rsp
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAP_X, ST_MAP_Y, ST_MAP_DONE, ST_QROW, ST_QCOL,
    ST_SCAN, ST_EMIT, ST_FINAL
  } state_e;

  logic [SideW-1:0]       rows_q, cols_q;
  logic [SizeW-1:0]       cw_q, ch_q;
  logic signed [PosW-1:0] orgx_q, orgy_q;

  logic [MaxAgents-1:0]   present_q;
  logic [CellW-1:0]       cell_mem [MaxAgents];

  state_e                 state_q;
  req_t                   r_q;
  logic                   second_q;
  logic [CellW-1:0]       newcell_q;
  logic [SlotW-1:0]       slot_q, rslot_q;
  logic signed [WideW-1:0] bound_q;
  logic [SlotW-1:0]       r_lo_q, r_hi_q, c_lo_q, c_hi_q;
  logic                   r_any_q, c_any_q;
  logic [SlotW-1:0]       cur_r_q, cur_c_q;
  logic [IdW-1:0]         aid_q;
  logic [CellW-1:0]       rd_cell_q;
  logic [CountW-1:0]      cnt_q;
  logic                   rsp_valid_q;
  rsp_t                   rsp_q;
  logic                   pend_valid_q;
  rsp_t                   pend_q;

  logic [SlotW-1:0] rows_m1, cols_m1;
  logic [SizeW-1:0] cw_eff, ch_eff;
  always_comb begin
    rows_m1 = (rows_q == '0) ? '0 : (rows_q > SideW'(MaxGridSide)) ? SlotW'(MaxGridSide - 1)
            : SlotW'(rows_q - 1'b1);
    cols_m1 = (cols_q == '0) ? '0 : (cols_q > SideW'(MaxGridSide)) ? SlotW'(MaxGridSide - 1)
            : SlotW'(cols_q - 1'b1);
    cw_eff = (cw_q == '0) ? SizeW'(1) : cw_q;
    ch_eff = (ch_q == '0) ? SizeW'(1) : ch_q;
  end

  // Shared step: next boundary and compare against the operand of the current phase.
  logic                    on_y;
  logic signed [WideW-1:0] step_size, next_bound, operand, q_lo, q_hi;
  logic [SlotW-1:0]        lim;
  always_comb begin
    on_y = (state_q == ST_MAP_Y) || (state_q == ST_QROW);
    step_size = on_y ? WideW'($signed({1'b0, ch_eff})) : WideW'($signed({1'b0, cw_eff}));
    lim = on_y ? rows_m1 : cols_m1;
    next_bound = bound_q + step_size;
    q_lo = on_y ? (WideW'(r_q.pos_y) - WideW'($signed({1'b0, r_q.radius})))
                : (WideW'(r_q.pos_x) - WideW'($signed({1'b0, r_q.radius})));
    q_hi = on_y ? (WideW'(r_q.pos_y) + WideW'($signed({1'b0, r_q.radius})))
                : (WideW'(r_q.pos_x) + WideW'($signed({1'b0, r_q.radius})));
    if (second_q) operand = on_y ? WideW'(r_q.old_y) : WideW'(r_q.old_x);
    else operand = on_y ? WideW'(r_q.pos_y) : WideW'(r_q.pos_x);
  end

  logic [CellW-1:0] mapped_cell, scan_cell;
  always_comb begin
    mapped_cell = CellW'(rslot_q) * CellW'({1'b0, cols_m1} + 5'd1) + CellW'(slot_q);
    scan_cell = CellW'(cur_r_q) * CellW'({1'b0, cols_m1} + 5'd1) + CellW'(cur_c_q);
  end

  logic out_free;
  assign out_free = !rsp_valid_q || rsp.ready;
  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == ST_IDLE) && !pend_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  logic match;
  assign match = present_q[aid_q] && (rd_cell_q == scan_cell) &&
                 !(aid_q == r_q.agent_id);

  logic scan_end;
  assign scan_end = (aid_q == IdW'(MaxAgents - 1)) && (cur_c_q == c_hi_q) &&
                    (cur_r_q == r_hi_q);

  always_ff @(posedge clk_i) begin
    rd_cell_q <= cell_mem[aid_q];
    if (state_q == ST_MAP_DONE && !second_q && (r_q.req_type == REQ_ADD)) begin
      cell_mem[r_q.agent_id] <= mapped_cell;
    end else if (state_q == ST_MAP_DONE && second_q && mapped_cell != newcell_q) begin
      cell_mem[r_q.agent_id] <= newcell_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SideW'(8);
      cols_q <= SideW'(8);
      cw_q <= SizeW'(256);
      ch_q <= SizeW'(256);
      orgx_q <= -PosW'(1024);
      orgy_q <= -PosW'(1024);
      present_q <= '0;
      state_q <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      r_q <= '0;
      second_q <= 1'b0;
      newcell_q <= '0;
      slot_q <= '0;
      rslot_q <= '0;
      bound_q <= '0;
      r_lo_q <= '0;
      r_hi_q <= '0;
      c_lo_q <= '0;
      c_hi_q <= '0;
      r_any_q <= 1'b0;
      c_any_q <= 1'b0;
      cur_r_q <= '0;
      cur_c_q <= '0;
      aid_q <= '0;
      cnt_q <= '0;
      rsp_q <= '0;
      pend_q <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.payload.index)
          CFG_ROWS:  rows_q <= cfg.payload.data[SideW-1:0];
          CFG_COLS:  cols_q <= cfg.payload.data[SideW-1:0];
          CFG_CW:    cw_q <= cfg.payload.data[SizeW-1:0];
          CFG_CH:    ch_q <= cfg.payload.data[SizeW-1:0];
          CFG_ORG_X: orgx_q <= cfg.payload.data;
          CFG_ORG_Y: orgy_q <= cfg.payload.data;
          default: ;
        endcase
      end

      // During a scan the pending neighbor waits until it is known whether it is the last.
      if (out_free && state_q != ST_EMIT) begin
        rsp_valid_q <= pend_valid_q;
        rsp_q <= pend_q;
        pend_valid_q <= 1'b0;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req.valid && !pend_valid_q) begin
            r_q <= req.payload;
            second_q <= 1'b0;
            cnt_q <= '0;
            case (req.payload.req_type)
              REQ_CLEAR: begin
                present_q <= '0;
                pend_valid_q <= 1'b1;
                pend_q <= '{found: 1'b0, neighbor_id: '0, cell_index: '0,
                            neighbor_count: '0, last: 1'b1};
                state_q <= ST_FINAL;
              end
              REQ_QUERY: begin
                slot_q <= '0;
                bound_q <= WideW'(orgy_q);
                r_any_q <= 1'b0;
                state_q <= ST_QROW;
              end
              default: begin
                slot_q <= '0;
                bound_q <= WideW'(orgx_q) + WideW'($signed({1'b0, cw_eff}));
                state_q <= ST_MAP_X;
              end
            endcase
          end
        end
        ST_MAP_X, ST_MAP_Y: begin
          // Slot advances while the operand is at or beyond the next boundary.
          if (slot_q != lim && operand >= bound_q) begin
            slot_q <= slot_q + 1'b1;
            bound_q <= next_bound;
          end else if (state_q == ST_MAP_X) begin
            rslot_q <= slot_q;
            slot_q <= '0;
            bound_q <= WideW'(orgy_q) + WideW'($signed({1'b0, ch_eff}));
            state_q <= ST_MAP_Y;
          end else begin
            rslot_q <= slot_q;
            slot_q <= rslot_q;
            state_q <= ST_MAP_DONE;
          end
        end
        ST_MAP_DONE: begin
          // Here rslot_q holds the row and slot_q the column.
          if (!second_q) begin
            newcell_q <= mapped_cell;
            if (r_q.req_type == REQ_ADD) begin
              present_q[r_q.agent_id] <= 1'b1;
              if (!pend_valid_q) begin
                pend_valid_q <= 1'b1;
                pend_q <= '{found: 1'b0, neighbor_id: '0, cell_index: mapped_cell,
                            neighbor_count: '0, last: 1'b1};
                state_q <= ST_FINAL;
              end
            end else begin
              second_q <= 1'b1;
              slot_q <= '0;
              bound_q <= WideW'(orgx_q) + WideW'($signed({1'b0, cw_eff}));
              state_q <= ST_MAP_X;
            end
          end else begin
            if (mapped_cell != newcell_q) present_q[r_q.agent_id] <= 1'b1;
            pend_valid_q <= 1'b1;
            pend_q <= '{found: 1'b0, neighbor_id: '0, cell_index: newcell_q,
                        neighbor_count: '0, last: 1'b1};
            second_q <= 1'b0;
            state_q <= ST_FINAL;
          end
        end
        ST_QROW, ST_QCOL: begin
          // Cell [bound, bound+size] overlaps [q_lo, q_hi].
          if (!(next_bound < q_lo || bound_q > q_hi)) begin
            if (state_q == ST_QROW) begin
              if (!r_any_q) r_lo_q <= slot_q;
              r_hi_q <= slot_q;
              r_any_q <= 1'b1;
            end else begin
              if (!c_any_q) c_lo_q <= slot_q;
              c_hi_q <= slot_q;
              c_any_q <= 1'b1;
            end
          end
          if (slot_q != lim) begin
            slot_q <= slot_q + 1'b1;
            bound_q <= next_bound;
          end else if (state_q == ST_QROW) begin
            slot_q <= '0;
            bound_q <= WideW'(orgx_q);
            c_any_q <= 1'b0;
            state_q <= ST_QCOL;
          end else begin
            state_q <= ST_SCAN;
            aid_q <= '0;
          end
        end
        ST_SCAN: begin
          // Rectangle fixed; set up the first row/col and prime the cell read, or end with no neighbors.
          cur_r_q <= r_lo_q;
          cur_c_q <= c_lo_q;
          aid_q <= '0;
          state_q <= (r_any_q && c_any_q) ? ST_EMIT : ST_FINAL;
          if (!(r_any_q && c_any_q)) begin
            pend_valid_q <= 1'b1;
            pend_q <= '{found: 1'b0, neighbor_id: '0, cell_index: '0,
                        neighbor_count: '0, last: 1'b1};
          end
        end
        ST_EMIT: begin
          // rd_cell_q is registered from aid_q; a slot is compared and stepped once second_q is set.
          if (!second_q) begin
            second_q <= 1'b1;
          end else if (!match || !pend_valid_q || out_free) begin
            second_q <= 1'b0;
            if (match) begin
              if (pend_valid_q) begin
                rsp_valid_q <= 1'b1;
                rsp_q <= pend_q;
              end
              pend_valid_q <= 1'b1;
              pend_q <= '{found: 1'b1, neighbor_id: aid_q, cell_index: scan_cell,
                          neighbor_count: cnt_q + 1'b1, last: scan_end};
              cnt_q <= cnt_q + 1'b1;
            end
            if (aid_q != IdW'(MaxAgents - 1)) begin
              aid_q <= aid_q + 1'b1;
            end else begin
              aid_q <= '0;
              if (cur_c_q != c_hi_q) begin
                cur_c_q <= cur_c_q + 1'b1;
              end else if (cur_r_q != r_hi_q) begin
                cur_c_q <= c_lo_q;
                cur_r_q <= cur_r_q + 1'b1;
              end else begin
                state_q <= ST_FINAL;
                if (!match && cnt_q == '0) begin
                  pend_valid_q <= 1'b1;
                  pend_q <= '{found: 1'b0, neighbor_id: '0, cell_index: '0,
                              neighbor_count: '0, last: 1'b1};
                end else if (!match) begin
                  pend_q.last <= 1'b1;
                end
              end
            end
          end
        end
        ST_FINAL: begin
          second_q <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb_uniform_grid_neighbor_query_unit.sv
module tb_uniform_grid_neighbor_query_unit;
  import ugnq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  ugnq_cfg_if cfg_ch();
  ugnq_req_if req_ch();
  ugnq_rsp_if rsp_ch();

  uniform_grid_neighbor_query_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg_ch.sink),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  // Grid settings and agent table as the predictor sees them.
  logic [SideW-1:0] m_rows, m_cols;
  logic [SizeW-1:0] m_cw, m_ch;
  logic signed [PosW-1:0] m_ox, m_oy;
  logic [CellW-1:0] m_cell [MaxAgents];
  logic m_present [MaxAgents];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  cfg_t pending_cfgs[$];

  int mismatches;
  bit timed_out;
  bit rsp_free;
  int hold_left;
  int hold_request;
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint side_of(logic [SideW-1:0] v);
    if (v < 1) return 1;
    if (v > MaxGridSide) return MaxGridSide;
    return v;
  endfunction

  function automatic longint axis_slot(longint p, longint org, longint sz, longint n);
    longint loc;
    longint q;
    loc = p - org;
    if (loc < 0) return 0;
    q = loc / sz;
    return (q > n - 1) ? n - 1 : q;
  endfunction

  function automatic logic [CellW-1:0] cell_of(longint x, longint y);
    longint rows, cols, r, c;
    rows = side_of(m_rows);
    cols = side_of(m_cols);
    r = axis_slot(y, m_oy, (m_ch == 0) ? 1 : m_ch, rows);
    c = axis_slot(x, m_ox, (m_cw == 0) ? 1 : m_cw, cols);
    return CellW'(r * cols + c);
  endfunction

  function automatic rsp_t mk(logic f, logic [IdW-1:0] id, logic [CellW-1:0] cidx,
                              logic [CountW-1:0] cnt, logic lst);
    rsp_t v;
    v.found = f;
    v.neighbor_id = id;
    v.cell_index = cidx;
    v.neighbor_count = cnt;
    v.last = lst;
    return v;
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void expect_rsp(rsp_t v);
    expected_rsps.insert(expected_rsps.size(), v);
  endfunction

  task automatic predict_grid(req_t r);
    longint rows, cols, cw, ch, qx0, qx1, qy0, qy1, by0, bx0;
    logic [CellW-1:0] nc;
    int n;
    int first;
    rsp_t v;
    case (req_e'(r.req_type))
      REQ_ADD, REQ_MOVE: begin
        nc = cell_of(r.pos_x, r.pos_y);
        if (req_e'(r.req_type) == REQ_ADD || nc != cell_of(r.old_x, r.old_y)) begin
          m_cell[r.agent_id] = nc;
          m_present[r.agent_id] = 1'b1;
        end
        expect_rsp(mk(1'b0, '0, nc, '0, 1'b1));
      end
      REQ_CLEAR: begin
        foreach (m_present[a]) m_present[a] = 1'b0;
        expect_rsp(mk(1'b0, '0, '0, '0, 1'b1));
      end
      default: begin
        rows = side_of(m_rows);
        cols = side_of(m_cols);
        cw = (m_cw == 0) ? 1 : m_cw;
        ch = (m_ch == 0) ? 1 : m_ch;
        qx0 = longint'(r.pos_x) - r.radius;
        qx1 = longint'(r.pos_x) + r.radius;
        qy0 = longint'(r.pos_y) - r.radius;
        qy1 = longint'(r.pos_y) + r.radius;
        n = 0;
        first = expected_rsps.size();
        for (longint rr = 0; rr < rows; rr++) begin
          by0 = longint'(m_oy) + rr * ch;
          if (by0 + ch < qy0 || by0 > qy1) continue;
          for (longint cc = 0; cc < cols; cc++) begin
            bx0 = longint'(m_ox) + cc * cw;
            if (bx0 + cw < qx0 || bx0 > qx1) continue;
            for (int a = 0; a < MaxAgents; a++) begin
              if (!m_present[a] || m_cell[a] != CellW'(rr * cols + cc) || a == r.agent_id)
                continue;
              n++;
              expect_rsp(mk(1'b1, IdW'(a), CellW'(rr * cols + cc), CountW'(n), 1'b0));
            end
          end
        end
        if (n == 0) begin
          expect_rsp(mk(1'b0, '0, '0, '0, 1'b1));
        end else begin
          v = expected_rsps[first + n - 1];
          v.last = 1'b1;
          expected_rsps[first + n - 1] = v;
        end
      end
    endcase
  endtask

  function automatic void apply_setting(cfg_t c);
    case (cfg_idx_e'(c.index))
      CFG_ROWS: m_rows = c.data[SideW-1:0];
      CFG_COLS: m_cols = c.data[SideW-1:0];
      CFG_CW: m_cw = c.data[SizeW-1:0];
      CFG_CH: m_ch = c.data[SizeW-1:0];
      CFG_ORG_X: m_ox = c.data;
      CFG_ORG_Y: m_oy = c.data;
      default: ;
    endcase
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_grid(req_ch.payload);
        void'(pending_reqs.pop_front());
      end
      if ((!req_ch.valid || req_ch.ready) || !req_ch.valid) begin
        if (req_ch.valid && !req_ch.ready) begin
        end else if (pending_reqs.size() > (req_ch.valid && req_ch.ready ? 0 : 0) &&
                     (calm || $urandom_range(99) >= 22)) begin
          req_ch.valid <= 1'b1;
          req_ch.payload <= pending_reqs[0];
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Configuration driver; only used while the grid is idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch.valid <= 1'b0;
      cfg_ch.payload <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_setting(cfg_ch.payload);
        void'(pending_cfgs.pop_front());
      end
      if (cfg_ch.valid && !cfg_ch.ready) begin
      end else if (pending_cfgs.size() > 0) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= pending_cfgs[0];
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Response monitor and ready generation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp_ch.payload);
        end else begin
          if (rsp_ch.payload !== expected_rsps[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_rsps[0], rsp_ch.payload);
          end
          void'(expected_rsps.pop_front());
        end
      end
      if (hold_request > 0 && hold_left == 0) begin
        hold_left <= hold_request;
        hold_request <= 0;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || $urandom_range(99) >= 22;
      end
    end
  end

  function automatic logic signed [PosW-1:0] rnd_pos(bit wide);
    if (wide) return PosW'($urandom);
    return PosW'($signed($urandom_range(2600)) - 1300);
  endfunction

  function automatic req_t mkreq(req_e t, int id, int px, int py, int ox, int oy, int rad);
    req_t r;
    r.req_type = t;
    r.agent_id = IdW'(id);
    r.pos_x = PosW'(px);
    r.pos_y = PosW'(py);
    r.old_x = PosW'(ox);
    r.old_y = PosW'(oy);
    r.radius = SizeW'(rad);
    return r;
  endfunction

  task automatic set_reg(cfg_idx_e idx, int val);
    cfg_t c;
    c.index = idx;
    c.data = CfgDataW'(val);
    pending_cfgs.insert(pending_cfgs.size(), c);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic configure(int rows, int cols, int cw, int ch, int ox, int oy);
    drain();
    set_reg(CFG_ROWS, rows);
    set_reg(CFG_COLS, cols);
    set_reg(CFG_CW, cw);
    set_reg(CFG_CH, ch);
    set_reg(CFG_ORG_X, ox);
    set_reg(CFG_ORG_Y, oy);
    while (pending_cfgs.size() > 0 || cfg_ch.valid) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, bit wide);
    int t;
    req_t r;
    for (int i = 0; i < count; i++) begin
      t = $urandom_range(99);
      r = '0;
      r.agent_id = IdW'($urandom_range(63));
      r.pos_x = rnd_pos(wide);
      r.pos_y = rnd_pos(wide);
      r.old_x = ($urandom_range(3) == 0) ? r.pos_x : rnd_pos(wide);
      r.old_y = ($urandom_range(3) == 0) ? r.pos_y : rnd_pos(wide);
      r.radius = wide ? SizeW'($urandom) : SizeW'($urandom_range(700));
      if (t < 40) r.req_type = REQ_ADD;
      else if (t < 62) r.req_type = REQ_MOVE;
      else if (t < 97) r.req_type = REQ_QUERY;
      else r.req_type = REQ_CLEAR;
      queue_req(r);
    end
  endtask

  initial begin
    m_rows = 8; m_cols = 8; m_cw = 256; m_ch = 256; m_ox = -1024; m_oy = -1024;
    foreach (m_present[a]) begin
      m_present[a] = 1'b0;
      m_cell[a] = '0;
    end
    mismatches = 0;
    hold_request = 0;
    calm = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(mkreq(REQ_ADD, 0, -1024, -1024, 0, 0, 0));
    queue_req(mkreq(REQ_ADD, 63, 1023, 1023, 0, 0, 0));
    queue_req(mkreq(REQ_ADD, 5, -8388608, 8388607, 0, 0, 0));
    queue_req(mkreq(REQ_ADD, 6, 8388607, -8388608, 0, 0, 0));
    queue_req(mkreq(REQ_ADD, 5, 0, 0, 0, 0, 0));
    queue_req(mkreq(REQ_MOVE, 7, 10, 10, 20, 20, 0));
    queue_req(mkreq(REQ_MOVE, 8, 10, 10, 300, 300, 0));
    queue_req(mkreq(REQ_ADD, 9, 256, 0, 0, 0, 0));
    queue_req(mkreq(REQ_QUERY, 5, 0, 0, 0, 0, 0));
    queue_req(mkreq(REQ_QUERY, 5, 128, 128, 0, 0, 128));
    queue_req(mkreq(REQ_QUERY, 40, 0, 0, 0, 0, 8388607));
    queue_req(mkreq(REQ_QUERY, 0, -8388608, -8388608, 0, 0, 0));
    queue_req(mkreq(REQ_QUERY, 63, 8388607, 8388607, 0, 0, 0));
    queue_req(mkreq(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_req(mkreq(REQ_QUERY, 1, 0, 0, 0, 0, 8388607));
    for (int a = 0; a < 64; a++)
      queue_req(mkreq(REQ_ADD, a, (a % 8) * 256 - 1024, (a / 8) * 256 - 1024, 0, 0, 0));
    queue_req(mkreq(REQ_QUERY, 70 % 64, 0, 0, 0, 0, 8388607));
    calm = 1;
    drain();
    calm = 0;

    // Receiver holds off while the sender keeps offering random requests.
    hold_request = 300;
    random_phase(20, 0);
    random_phase(60, 0);
    calm = 1;
    random_phase(40, 0);
    drain();
    calm = 0;

    configure(16, 16, 1, 1, -8, -8);
    random_phase(80, 0);
    configure(1, 1, 8388607, 8388607, -8388608, -8388608);
    random_phase(40, 1);
    configure(0, 31, 0, 0, 8388607, 100);
    random_phase(40, 1);
    configure(3, 12, 100, 300, -600, -200);
    random_phase(60, 0);
    configure(16, 16, 160, 160, -1280, -1280);
    random_phase(60, 0);
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0 && !timed_out) begin
      $display("PASS uniform_grid_neighbor_query_unit");
    end else begin
      $display("FAIL uniform_grid_neighbor_query_unit");
    end
    $finish;
  end

  initial begin
    timed_out = 0;
    #250ms;
    timed_out = 1;
    $display("FAIL uniform_grid_neighbor_query_unit");
    $finish;
  end

endmodule
